// ----- rtl/first_fit_block_range_allocator_macros.svh -----
// Assertion helpers, clocked on clk_i and held off during reset.
`ifndef FIRST_FIT_BLOCK_RANGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_RANGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define FFBRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FFBRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ffbra_pkg.sv -----
package ffbra_pkg;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FREE_IGNORED = 3'd1,
    ST_BAD_TYPE     = 3'd2,
    ST_NO_SLOT      = 3'd3,
    ST_TABLE_FULL   = 3'd4
  } status_e;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] CFG_DED_THRESH = 2'd1;
  localparam logic [1:0] CFG_TYPE_COUNT = 2'd2;

  localparam logic [39:0] BLOCK_SIZE_RST = 40'd67108864;
  localparam logic [39:0] DED_THRESH_RST = BLOCK_SIZE_RST >> 1;
  localparam logic [5:0]  TYPE_COUNT_RST = 6'd32;
  localparam logic [31:0] CNT_MAX        = 32'hFFFF_FFFF;
  localparam logic [47:0] BYTES_MAX      = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        req_type;
    logic [39:0] req_size;
    logic [5:0]  align_log2;
    logic [4:0]  memory_type;
    logic        resource_kind;
    logic        handle_valid;
    logic        handle_dedicated;
    logic [3:0]  handle_block;
    logic [39:0] handle_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        got_dedicated;
    logic [3:0]  got_block;
    logic [39:0] got_offset;
    logic [31:0] live_total;
    logic [47:0] used_total;
    logic [47:0] reserved_total;
    logic [4:0]  open_blocks;
    logic [31:0] dedicated_live;
  } rsp_t;

endpackage

// ----- rtl/ffbra_if.sv -----
interface ffbra_req_if;
  import ffbra_pkg::*;
  logic valid;
  logic ready;
  req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface ffbra_rsp_if;
  import ffbra_pkg::*;
  logic valid;
  logic ready;
  rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

// ----- rtl/first_fit_block_range_allocator.sv -----
// First-fit pooled block allocator: one request at a time, one response per request.
// Free-range tables of all slots live in one table memory with one read and one write
// port, and the requests that use them are walked through it by a small sequencer. An
// allocate visits slots and examines their range entries in turn; a free walks its
// slot's table; a split or free that moves table entries shifts each entry moved; every
// request ends with a statistics pass over all NUM_SLOTS slots. A new request is taken
// while the previous response still waits. Table entries of a slot are read only below
// its range count, so no clearing pass is needed after reset.
`include "first_fit_block_range_allocator_macros.svh"

module first_fit_block_range_allocator #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned SIZE_BITS  = 40,
  parameter int unsigned MAX_TYPES  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [39:0] cfg_wdata_i,
  ffbra_req_if.sink   req_i,
  ffbra_rsp_if.source rsp_o
);
  import ffbra_pkg::*;

  localparam int unsigned SLW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned IW    = $clog2(MAX_RANGES);
  localparam int unsigned CW    = $clog2(MAX_RANGES + 1);
  localparam int unsigned AW    = SLW + IW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned SB    = SIZE_BITS;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] A_SLOT  = 5'd2;
  localparam logic [4:0] A_RD    = 5'd3;
  localparam logic [4:0] A_E1    = 5'd4;
  localparam logic [4:0] A_E2    = 5'd5;
  localparam logic [4:0] A_E3    = 5'd6;
  localparam logic [4:0] A_E4    = 5'd7;
  localparam logic [4:0] O_SLOT  = 5'd8;
  localparam logic [4:0] F_RD    = 5'd9;
  localparam logic [4:0] F_E     = 5'd10;
  localparam logic [4:0] F_DEC   = 5'd11;
  localparam logic [4:0] F_DEC2  = 5'd12;
  localparam logic [4:0] F_UPD   = 5'd13;
  localparam logic [4:0] SH_RD   = 5'd14;
  localparam logic [4:0] SH_WR   = 5'd15;
  localparam logic [4:0] W1      = 5'd16;
  localparam logic [4:0] W2      = 5'd17;
  localparam logic [4:0] ST_INIT = 5'd18;
  localparam logic [4:0] ST_ACC  = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;

  typedef struct packed {
    logic [SB-1:0] st;
    logic [SB-1:0] ln;
  } ent_t;

  // configuration
  logic [39:0] bs_q, thr_q;
  logic [5:0]  mtc_q;

  // slot state
  logic          open_q  [NUM_SLOTS];
  logic [4:0]    type_q  [NUM_SLOTS];
  logic          kind_q  [NUM_SLOTS];
  logic [SB-1:0] bytes_q [NUM_SLOTS];
  logic [31:0]   live_q  [NUM_SLOTS];
  logic [SB-1:0] used_q  [NUM_SLOTS];
  logic [CW-1:0] cnt_q   [NUM_SLOTS];
  logic [31:0]   ded_cnt_q;
  logic [47:0]   ded_bytes_q;

  // sequencer
  logic [4:0]     state_q;
  req_t           rq_q;
  logic [SLW-1:0] s_q;
  logic [CW-1:0]  i_q, n_q, k_q, lim_q;
  logic           sh_rm_q;
  logic [SB-1:0]  st_q, ln_q, rem_q;
  logic [63:0]    al_q, pad_q;
  ent_t           prev_q, cur_q;
  logic           have_cur_q, mnext_q, mprev_q;
  logic [SB:0]    len_q;
  logic           w1_en_q, w2_en_q;
  logic [IW-1:0]  w1_idx_q, w2_idx_q;
  ent_t           w1_dat_q, w2_dat_q;
  logic [2:0]     status_q;
  logic           gded_q;
  logic [SLW-1:0] gblk_q;
  logic [SB-1:0]  goff_q;
  logic [31:0]    acc_live_q;
  logic [47:0]    acc_used_q, acc_resv_q;
  logic [SLW:0]   acc_open_q;
  logic           out_valid_q;
  rsp_t           out_q;

  // table memory
  ent_t          tbl_mem [DEPTH];
  ent_t          rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  ent_t          mem_wd;

  // combinational helpers
  logic [SB-1:0]  size_w, off_w, trail_w, after_w, bsz_raw, bsz_w;
  logic [SLW-1:0] hb_s;
  logic           hb_oor, bad_type, last_slot, slot_match;
  logic [63:0]    a_pow;
  logic [32:0]    live_sum;
  logic [48:0]    used_sum, resv_sum, ded_sum;
  logic [31:0]    fr_live;
  logic [SB-1:0]  fr_used;
  logic           fr_close;
  logic [SB:0]    sl_used_sum, fr_len;

  assign size_w     = SB'(rq_q.req_size);
  assign off_w      = SB'(rq_q.handle_offset);
  assign hb_s       = SLW'(rq_q.handle_block);
  assign hb_oor     = 9'(rq_q.handle_block) >= 9'(NUM_SLOTS);
  assign bad_type   = (6'(rq_q.memory_type) >= mtc_q) ||
                      (6'(rq_q.memory_type) >= 6'(MAX_TYPES));
  assign last_slot  = s_q == SLW'(NUM_SLOTS - 1);
  assign slot_match = open_q[s_q] && (type_q[s_q] == rq_q.memory_type) &&
                      (kind_q[s_q] == rq_q.resource_kind);
  assign a_pow      = 64'(1) << rq_q.align_log2;
  assign trail_w    = rem_q - size_w;
  assign after_w    = SB'(al_q) + size_w;
  assign bsz_raw    = SB'(bs_q);
  assign bsz_w      = (size_w > bsz_raw) ? size_w : bsz_raw;
  assign live_sum   = {1'b0, acc_live_q} + {1'b0, live_q[s_q]};
  assign used_sum   = {1'b0, acc_used_q} + 49'(used_q[s_q]);
  assign resv_sum   = {1'b0, acc_resv_q} + 49'(bytes_q[s_q]);
  assign ded_sum    = {1'b0, ded_bytes_q} + 49'(size_w);
  assign sl_used_sum = {1'b0, used_q[s_q]} + {1'b0, size_w};
  assign fr_live    = (live_q[s_q] == '0) ? '0 : live_q[s_q] - 32'd1;
  assign fr_used    = (size_w >= used_q[s_q]) ? '0 : used_q[s_q] - size_w;
  assign fr_close   = fr_live == '0;
  assign fr_len     = mnext_q ? len_q : {1'b0, size_w};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_q;
    mem_ra = '0;
    case (state_q)
      A_RD, F_RD: mem_ra = {s_q, i_q[IW-1:0]};
      SH_RD: begin
        if (sh_rm_q) begin
          mem_ra = {s_q, IW'(k_q + CW'(1))};
        end else begin
          mem_ra = {s_q, IW'(k_q - CW'(1))};
        end
      end
      SH_WR: begin
        mem_we = 1'b1;
        mem_wa = {s_q, k_q[IW-1:0]};
      end
      W1: begin
        mem_we = w1_en_q;
        mem_wa = {s_q, w1_idx_q};
        mem_wd = w1_dat_q;
      end
      W2: begin
        mem_we = w2_en_q;
        mem_wa = {s_q, w2_idx_q};
        mem_wd = w2_dat_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    rd_q <= tbl_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q  <= BLOCK_SIZE_RST;
      thr_q <= DED_THRESH_RST;
      mtc_q <= TYPE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_SIZE: bs_q  <= cfg_wdata_i;
        CFG_DED_THRESH: thr_q <= cfg_wdata_i;
        CFG_TYPE_COUNT: mtc_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      s_q         <= '0;
      ded_cnt_q   <= '0;
      ded_bytes_q <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        open_q[s]  <= 1'b0;
        bytes_q[s] <= '0;
        live_q[s]  <= '0;
        used_q[s]  <= '0;
        cnt_q[s]   <= '0;
      end
    end else begin
      if (rsp_o.valid && rsp_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            rq_q       <= req_i.req;
            status_q   <= ST_OK;
            gded_q     <= 1'b0;
            gblk_q     <= '0;
            goff_q     <= '0;
            i_q        <= '0;
            have_cur_q <= 1'b0;
            w1_en_q    <= 1'b0;
            w2_en_q    <= 1'b0;
            sh_rm_q    <= 1'b0;
            state_q    <= S_START;
          end
        end

        S_START: begin
          if (rq_q.req_type == REQ_ALLOC) begin
            if (bad_type) begin
              status_q <= ST_BAD_TYPE;
              state_q  <= ST_INIT;
            end else if (48'(size_w) >= 48'(thr_q)) begin
              ded_cnt_q   <= (ded_cnt_q == CNT_MAX) ? CNT_MAX : ded_cnt_q + 32'd1;
              ded_bytes_q <= ded_sum[48] ? BYTES_MAX : ded_sum[47:0];
              gded_q      <= 1'b1;
              state_q     <= ST_INIT;
            end else begin
              s_q     <= '0;
              state_q <= A_SLOT;
            end
          end else if (!rq_q.handle_valid) begin
            status_q <= ST_FREE_IGNORED;
            state_q  <= ST_INIT;
          end else if (rq_q.handle_dedicated) begin
            if (ded_cnt_q == '0) begin
              status_q <= ST_FREE_IGNORED;
            end else begin
              ded_cnt_q   <= ded_cnt_q - 32'd1;
              ded_bytes_q <= (48'(size_w) >= ded_bytes_q) ? '0
                                                           : ded_bytes_q - 48'(size_w);
            end
            state_q <= ST_INIT;
          end else if (hb_oor || !open_q[hb_s]) begin
            status_q <= ST_FREE_IGNORED;
            state_q  <= ST_INIT;
          end else begin
            s_q     <= hb_s;
            n_q     <= cnt_q[hb_s];
            state_q <= (size_w == '0) ? F_UPD : F_RD;
          end
        end

        A_SLOT: begin
          if (slot_match) begin
            i_q     <= '0;
            n_q     <= cnt_q[s_q];
            state_q <= A_RD;
          end else if (last_slot) begin
            s_q     <= '0;
            state_q <= O_SLOT;
          end else begin
            s_q <= s_q + SLW'(1);
          end
        end

        A_RD: begin
          if (i_q < n_q) begin
            state_q <= A_E1;
          end else if (last_slot) begin
            s_q     <= '0;
            state_q <= O_SLOT;
          end else begin
            s_q     <= s_q + SLW'(1);
            state_q <= A_SLOT;
          end
        end

        A_E1: begin
          st_q    <= rd_q.st;
          ln_q    <= rd_q.ln;
          al_q    <= (64'(rd_q.st) + a_pow - 64'(1)) & ~(a_pow - 64'(1));
          state_q <= A_E2;
        end

        A_E2: begin
          pad_q   <= al_q - 64'(st_q);
          state_q <= A_E3;
        end

        A_E3: begin
          if (64'(ln_q) < pad_q) begin
            i_q     <= i_q + CW'(1);
            state_q <= A_RD;
          end else begin
            rem_q   <= ln_q - SB'(pad_q);
            state_q <= A_E4;
          end
        end

        A_E4: begin
          if (rem_q < size_w) begin
            i_q     <= i_q + CW'(1);
            state_q <= A_RD;
          end else if (pad_q != '0 && trail_w != '0 && n_q >= CW'(MAX_RANGES)) begin
            status_q <= ST_TABLE_FULL;
            state_q  <= ST_INIT;
          end else begin
            live_q[s_q] <= (live_q[s_q] == CNT_MAX) ? CNT_MAX : live_q[s_q] + 32'd1;
            used_q[s_q] <= sl_used_sum[SB] ? '1 : sl_used_sum[SB-1:0];
            gblk_q      <= s_q;
            goff_q      <= SB'(al_q);
            if (pad_q == '0 && trail_w == '0) begin
              sh_rm_q    <= 1'b1;
              k_q        <= i_q;
              cnt_q[s_q] <= n_q - CW'(1);
              state_q    <= SH_RD;
            end else if (pad_q == '0) begin
              w1_en_q  <= 1'b1;
              w1_idx_q <= i_q[IW-1:0];
              w1_dat_q <= '{st: after_w, ln: trail_w};
              state_q  <= W1;
            end else begin
              w2_en_q  <= 1'b1;
              w2_idx_q <= i_q[IW-1:0];
              w2_dat_q <= '{st: st_q, ln: SB'(pad_q)};
              if (trail_w != '0) begin
                w1_en_q    <= 1'b1;
                w1_idx_q   <= IW'(i_q + CW'(1));
                w1_dat_q   <= '{st: after_w, ln: trail_w};
                sh_rm_q    <= 1'b0;
                k_q        <= n_q;
                lim_q      <= i_q + CW'(1);
                cnt_q[s_q] <= n_q + CW'(1);
                state_q    <= SH_RD;
              end else begin
                state_q <= W1;
              end
            end
          end
        end

        O_SLOT: begin
          if (!open_q[s_q]) begin
            open_q[s_q]  <= 1'b1;
            type_q[s_q]  <= rq_q.memory_type;
            kind_q[s_q]  <= rq_q.resource_kind;
            bytes_q[s_q] <= bsz_w;
            live_q[s_q]  <= 32'd1;
            used_q[s_q]  <= size_w;
            gblk_q       <= s_q;
            goff_q       <= '0;
            w1_idx_q     <= '0;
            w1_dat_q     <= '{st: size_w, ln: bsz_w - size_w};
            w1_en_q      <= bsz_w > size_w;
            cnt_q[s_q]   <= (bsz_w > size_w) ? CW'(1) : '0;
            state_q      <= W1;
          end else if (last_slot) begin
            status_q <= ST_NO_SLOT;
            state_q  <= ST_INIT;
          end else begin
            s_q <= s_q + SLW'(1);
          end
        end

        F_RD: begin
          state_q <= (i_q < n_q) ? F_E : F_DEC;
        end

        F_E: begin
          if (rd_q.st < off_w) begin
            prev_q  <= rd_q;
            i_q     <= i_q + CW'(1);
            state_q <= F_RD;
          end else begin
            cur_q      <= rd_q;
            have_cur_q <= 1'b1;
            state_q    <= F_DEC;
          end
        end

        F_DEC: begin
          mnext_q <= have_cur_q &&
                     (({1'b0, off_w} + {1'b0, size_w}) == {1'b0, cur_q.st});
          mprev_q <= (i_q != '0) &&
                     (({1'b0, prev_q.st} + {1'b0, prev_q.ln}) == {1'b0, off_w});
          len_q   <= {1'b0, size_w} + {1'b0, cur_q.ln};
          state_q <= F_DEC2;
        end

        F_DEC2: begin
          if (!mnext_q && !mprev_q && n_q >= CW'(MAX_RANGES)) begin
            status_q <= ST_TABLE_FULL;
            state_q  <= ST_INIT;
          end else begin
            w1_en_q <= 1'b1;
            if (mprev_q) begin
              w1_idx_q <= IW'(i_q - CW'(1));
              w1_dat_q <= '{st: prev_q.st, ln: prev_q.ln + SB'(fr_len)};
            end else begin
              w1_idx_q <= i_q[IW-1:0];
              w1_dat_q <= '{st: off_w, ln: SB'(fr_len)};
            end
            if (mnext_q && mprev_q) begin
              sh_rm_q    <= 1'b1;
              k_q        <= i_q;
              cnt_q[s_q] <= fr_close ? '0 : n_q - CW'(1);
              state_q    <= SH_RD;
            end else if (!mnext_q && !mprev_q) begin
              sh_rm_q    <= 1'b0;
              k_q        <= n_q;
              lim_q      <= i_q;
              cnt_q[s_q] <= fr_close ? '0 : n_q + CW'(1);
              state_q    <= SH_RD;
            end else begin
              if (fr_close) begin
                cnt_q[s_q] <= '0;
              end
              state_q <= W1;
            end
            live_q[s_q] <= fr_live;
            used_q[s_q] <= fr_close ? '0 : fr_used;
            if (fr_close) begin
              open_q[s_q]  <= 1'b0;
              bytes_q[s_q] <= '0;
            end
          end
        end

        F_UPD: begin
          live_q[s_q] <= fr_live;
          used_q[s_q] <= fr_close ? '0 : fr_used;
          if (fr_close) begin
            open_q[s_q]  <= 1'b0;
            cnt_q[s_q]   <= '0;
            bytes_q[s_q] <= '0;
          end
          state_q <= ST_INIT;
        end

        SH_RD: begin
          if (sh_rm_q) begin
            state_q <= ((k_q + CW'(1)) < n_q) ? SH_WR : W1;
          end else begin
            state_q <= (k_q > lim_q) ? SH_WR : W1;
          end
        end

        SH_WR: begin
          k_q     <= sh_rm_q ? k_q + CW'(1) : k_q - CW'(1);
          state_q <= SH_RD;
        end

        W1: state_q <= W2;

        W2: state_q <= ST_INIT;

        ST_INIT: begin
          acc_live_q <= ded_cnt_q;
          acc_used_q <= ded_bytes_q;
          acc_resv_q <= ded_bytes_q;
          acc_open_q <= '0;
          s_q        <= '0;
          state_q    <= ST_ACC;
        end

        ST_ACC: begin
          if (open_q[s_q]) begin
            acc_live_q <= live_sum[32] ? CNT_MAX : live_sum[31:0];
            acc_used_q <= used_sum[48] ? BYTES_MAX : used_sum[47:0];
            acc_resv_q <= resv_sum[48] ? BYTES_MAX : resv_sum[47:0];
            acc_open_q <= acc_open_q + (SLW+1)'(1);
          end
          if (last_slot) begin
            state_q <= S_DONE;
          end else begin
            s_q <= s_q + SLW'(1);
          end
        end

        S_DONE: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_q.status         <= status_q;
            out_q.got_dedicated  <= gded_q;
            out_q.got_block      <= 4'(gblk_q);
            out_q.got_offset     <= 40'(goff_q);
            out_q.live_total     <= acc_live_q;
            out_q.used_total     <= acc_used_q;
            out_q.reserved_total <= acc_resv_q;
            out_q.open_blocks    <= 5'(acc_open_q);
            out_q.dedicated_live <= ded_cnt_q;
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready = state_q == S_IDLE;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.rsp   = out_q;

  `FFBRA_ASSERT_NXT(a_busy_after_req, req_i.valid && req_i.ready, !req_i.ready, "busy flag")
  `FFBRA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q[s_q] <= CW'(MAX_RANGES), "range count overflow")
  `FFBRA_ASSERT_IMP(a_closed_idle, !open_q[s_q], live_q[s_q] == '0, "closed slot has live")
  `FFBRA_ASSERT_IMP(a_rsp_from_done, $rose(out_valid_q), $past(state_q) == S_DONE, "stray rsp")

endmodule

// ----- dv/ffbra_checker.sv -----
module ffbra_checker
  import ffbra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [39:0] cfg_wdata_i,
  ffbra_req_if        req_mon,
  ffbra_rsp_if        rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned NSLOT = 16;
  localparam int unsigned NRNG  = 64;
  localparam logic [63:0] SZ_M  = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] W48_M = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] CNT_M = 64'hFFFF_FFFF;

  logic [63:0] blk_bytes_cfg, ded_thr_cfg;
  logic [5:0]  type_cnt_cfg;

  bit          slot_open_q [NSLOT];
  logic [4:0]  slot_type_q [NSLOT];
  bit          slot_kind_q [NSLOT];
  logic [63:0] slot_bytes_q[NSLOT];
  logic [63:0] slot_live_q [NSLOT];
  logic [63:0] slot_used_q [NSLOT];
  int          rng_cnt_q   [NSLOT];
  logic [63:0] rng_start_q [NSLOT][NRNG];
  logic [63:0] rng_len_q   [NSLOT][NRNG];
  logic [63:0] ded_cnt_q, ded_bytes_q;

  rsp_t        expected_rsp_q[$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_rsp_q.size();

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    return (a > lim || b > lim - a) ? lim : a + b;
  endfunction

  function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
    return (b >= a) ? 64'd0 : a - b;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp);
    if (got !== exp) report($sformatf("%s got %0h expected %0h", name, got, exp));
  endtask

  task automatic clear_model();
    blk_bytes_cfg = {24'd0, BLOCK_SIZE_RST};
    ded_thr_cfg   = {24'd0, DED_THRESH_RST};
    type_cnt_cfg  = TYPE_COUNT_RST;
    for (int s = 0; s < NSLOT; s++) begin
      slot_open_q[s]  = 0;
      slot_type_q[s]  = '0;
      slot_kind_q[s]  = 0;
      slot_bytes_q[s] = '0;
      slot_live_q[s]  = '0;
      slot_used_q[s]  = '0;
      rng_cnt_q[s]    = 0;
    end
    ded_cnt_q   = '0;
    ded_bytes_q = '0;
  endtask

  task automatic rng_remove(input int s, input int i);
    for (int k = i; k + 1 < rng_cnt_q[s]; k++) begin
      rng_start_q[s][k] = rng_start_q[s][k+1];
      rng_len_q[s][k]   = rng_len_q[s][k+1];
    end
    rng_cnt_q[s]--;
  endtask

  task automatic rng_insert(input int s, input int i, input logic [63:0] st,
                            input logic [63:0] ln);
    for (int k = rng_cnt_q[s]; k > i; k--) begin
      rng_start_q[s][k] = rng_start_q[s][k-1];
      rng_len_q[s][k]   = rng_len_q[s][k-1];
    end
    rng_start_q[s][i] = st;
    rng_len_q[s][i]   = ln;
    rng_cnt_q[s]++;
  endtask

  task automatic allocate(input req_t r, inout rsp_t e);
    logic [63:0] sz, a, st, ln, al, pad, trail, after, bs;
    bit done;
    sz   = {24'd0, r.req_size};
    done = 0;
    if (r.memory_type >= type_cnt_cfg) begin
      e.status = ST_BAD_TYPE;
    end else if (sz >= ded_thr_cfg) begin
      ded_cnt_q       = sat_add(ded_cnt_q, 1, CNT_M);
      ded_bytes_q     = sat_add(ded_bytes_q, sz, W48_M);
      e.got_dedicated = 1'b1;
    end else begin
      a = 64'd1 << r.align_log2;
      for (int s = 0; s < NSLOT && !done; s++) begin
        if (slot_open_q[s] && slot_type_q[s] == r.memory_type &&
            slot_kind_q[s] == r.resource_kind) begin
          for (int i = 0; i < rng_cnt_q[s] && !done; i++) begin
            st  = rng_start_q[s][i];
            ln  = rng_len_q[s][i];
            al  = (st + a - 64'd1) & ~(a - 64'd1);
            pad = al - st;
            if (!(ln < pad || ln - pad < sz)) begin
              done  = 1;
              trail = ln - pad - sz;
              after = (al + sz) & SZ_M;
              if (pad == 0 && trail == 0) begin
                rng_remove(s, i);
              end else if (pad == 0) begin
                rng_start_q[s][i] = after;
                rng_len_q[s][i]   = trail;
              end else if (trail > 0 && rng_cnt_q[s] >= NRNG) begin
                e.status = ST_TABLE_FULL;
              end else begin
                if (trail > 0) rng_insert(s, i + 1, after, trail);
                rng_len_q[s][i] = pad;
              end
              if (e.status == ST_OK) begin
                slot_live_q[s] = sat_add(slot_live_q[s], 1, CNT_M);
                slot_used_q[s] = sat_add(slot_used_q[s], sz, SZ_M);
                e.got_block    = 4'(s);
                e.got_offset   = al[39:0];
              end
            end
          end
        end
      end
      for (int s = 0; s < NSLOT && !done; s++) begin
        if (!slot_open_q[s]) begin
          done = 1;
          bs   = blk_bytes_cfg & SZ_M;
          if (sz > bs) bs = sz;
          slot_open_q[s]  = 1;
          slot_type_q[s]  = r.memory_type;
          slot_kind_q[s]  = r.resource_kind;
          slot_bytes_q[s] = bs;
          slot_live_q[s]  = 1;
          slot_used_q[s]  = sz;
          rng_cnt_q[s]    = 0;
          if (bs > sz) begin
            rng_start_q[s][0] = sz;
            rng_len_q[s][0]   = bs - sz;
            rng_cnt_q[s]      = 1;
          end
          e.got_block = 4'(s);
        end
      end
      if (!done) e.status = ST_NO_SLOT;
    end
  endtask

  task automatic release_range(input req_t r, inout rsp_t e);
    logic [63:0] sz, off, len;
    int s, n, p;
    bit mnext, mprev;
    sz = {24'd0, r.req_size};
    s  = r.handle_block;
    if (!r.handle_valid) begin
      e.status = ST_FREE_IGNORED;
    end else if (r.handle_dedicated) begin
      if (ded_cnt_q == 0) begin
        e.status = ST_FREE_IGNORED;
      end else begin
        ded_cnt_q--;
        ded_bytes_q = sat_sub(ded_bytes_q, sz);
      end
    end else if (!slot_open_q[s]) begin
      e.status = ST_FREE_IGNORED;
    end else begin
      off = {24'd0, r.handle_offset};
      if (sz > 0) begin
        n = rng_cnt_q[s];
        p = 0;
        while (p < n && rng_start_q[s][p] < off) p++;
        mnext = (p < n) && (off + sz == rng_start_q[s][p]);
        mprev = 0;
        if (p > 0) mprev = (rng_start_q[s][p-1] + rng_len_q[s][p-1] == off);
        if (!mnext && !mprev && n >= NRNG) begin
          e.status = ST_TABLE_FULL;
        end else begin
          len = sz;
          if (mnext) begin
            len += rng_len_q[s][p];
            rng_remove(s, p);
          end
          if (mprev) rng_len_q[s][p-1] = (rng_len_q[s][p-1] + len) & SZ_M;
          else rng_insert(s, p, off, len & SZ_M);
        end
      end
      if (e.status == ST_OK) begin
        if (slot_live_q[s] > 0) slot_live_q[s]--;
        slot_used_q[s] = sat_sub(slot_used_q[s], sz);
        if (slot_live_q[s] == 0) begin
          slot_open_q[s]  = 0;
          rng_cnt_q[s]    = 0;
          slot_bytes_q[s] = '0;
          slot_used_q[s]  = '0;
        end
      end
    end
  endtask

  task automatic predict_response(input req_t r, output rsp_t e);
    logic [63:0] live, used, resv;
    int nopen;
    e = '0;
    e.status = ST_OK;
    if (r.req_type == REQ_ALLOC) allocate(r, e);
    else release_range(r, e);
    live  = ded_cnt_q;
    used  = ded_bytes_q;
    resv  = ded_bytes_q;
    nopen = 0;
    for (int s = 0; s < NSLOT; s++) begin
      if (slot_open_q[s]) begin
        nopen++;
        live = sat_add(live, slot_live_q[s], CNT_M);
        used = sat_add(used, slot_used_q[s], W48_M);
        resv = sat_add(resv, slot_bytes_q[s], W48_M);
      end
    end
    e.live_total     = live[31:0];
    e.used_total     = used[47:0];
    e.reserved_total = resv[47:0];
    e.open_blocks    = 5'(nopen);
    e.dedicated_live = ded_cnt_q[31:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e, g;
    if (!rst_ni) begin
      clear_model();
      expected_rsp_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCK_SIZE: blk_bytes_cfg = {24'd0, cfg_wdata_i};
          CFG_DED_THRESH: ded_thr_cfg   = {24'd0, cfg_wdata_i};
          CFG_TYPE_COUNT: type_cnt_cfg  = cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        g = rsp_mon.rsp;
        if (expected_rsp_q.size() == 0) begin
          report("response with no request outstanding");
        end else begin
          e = expected_rsp_q.pop_front();
          check_field("status", g.status, e.status);
          check_field("got_dedicated", g.got_dedicated, e.got_dedicated);
          check_field("got_block", g.got_block, e.got_block);
          check_field("got_offset", g.got_offset, e.got_offset);
          check_field("live_total", g.live_total, e.live_total);
          check_field("used_total", g.used_total, e.used_total);
          check_field("reserved_total", g.reserved_total, e.reserved_total);
          check_field("open_blocks", g.open_blocks, e.open_blocks);
          check_field("dedicated_live", g.dedicated_live, e.dedicated_live);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_response(req_mon.req, e);
        expected_rsp_q.insert(expected_rsp_q.size(), e);
      end
    end
  end

endmodule

// ----- dv/tb_first_fit_block_range_allocator.sv -----
module tb_first_fit_block_range_allocator;
  import ffbra_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct {
    bit          ded;
    logic [3:0]  blk;
    logic [39:0] off;
    logic [39:0] size;
  } handle_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [39:0] cfg_wdata;
  int unsigned fail_count, pending;

  ffbra_req_if req_if ();
  ffbra_rsp_if rsp_if ();

  first_fit_block_range_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  ffbra_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  int          send_idle, recv_idle;
  int unsigned cycles, n_alloc, n_free, n_ok, n_settings;
  logic [39:0] thr_now, size_cap;
  req_t        sent_q[$];
  handle_t     live_handles[$];

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial rsp_if.ready = 1'b0;
  always @(posedge clk_i) rsp_if.ready <= rst_ni && ($urandom_range(99) >= recv_idle);

  // requests and responses pair up in order; keep successful handles for later frees
  always @(posedge clk_i) begin
    req_t r;
    handle_t h;
    if (rst_ni && rsp_if.valid && rsp_if.ready && sent_q.size() > 0) begin
      r = sent_q.pop_front();
      if (rsp_if.rsp.status == ST_OK) n_ok++;
      if (r.req_type == REQ_ALLOC && rsp_if.rsp.status == ST_OK) begin
        h.ded  = rsp_if.rsp.got_dedicated;
        h.blk  = rsp_if.rsp.got_block;
        h.off  = rsp_if.rsp.got_offset;
        h.size = r.req_size;
        live_handles.insert(live_handles.size(), h);
      end
    end
    if (rst_ni && req_if.valid && req_if.ready) sent_q.insert(sent_q.size(), req_if.req);
  end

  task automatic send_request(input req_t r);
    if ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    req_if.valid <= 1'b1;
    req_if.req   <= r;
    if (r.req_type == REQ_ALLOC) n_alloc++;
    else n_free++;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [39:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic req_t alloc_req(logic [39:0] size, logic [5:0] alog, logic [4:0] mtype,
                                     logic kind);
    req_t r;
    r = '0;
    r.req_type      = REQ_ALLOC;
    r.req_size      = size;
    r.align_log2    = alog;
    r.memory_type   = mtype;
    r.resource_kind = kind;
    return r;
  endfunction

  function automatic req_t free_req(logic hv, logic hd, logic [3:0] blk, logic [39:0] off,
                                    logic [39:0] size);
    req_t r;
    r = '0;
    r.req_type         = REQ_FREE;
    r.req_size         = size;
    r.handle_valid     = hv;
    r.handle_dedicated = hd;
    r.handle_block     = blk;
    r.handle_offset    = off;
    return r;
  endfunction

  task automatic random_request(output req_t r);
    handle_t h;
    int idx;
    r = req_t'($bits(req_t)'({$urandom, $urandom, $urandom, $urandom}));
    if ($urandom_range(99) < 8) return;
    if (live_handles.size() > 0 && $urandom_range(99) < 45) begin
      idx = $urandom_range(live_handles.size() - 1);
      h   = live_handles[idx];
      live_handles.delete(idx);
      r.req_type         = REQ_FREE;
      r.handle_valid     = 1'b1;
      r.handle_dedicated = h.ded;
      r.handle_block     = h.blk;
      r.handle_offset    = h.off;
      r.req_size         = h.size;
    end else begin
      r.req_type = REQ_ALLOC;
      if ($urandom_range(99) < 85) r.memory_type = 5'($urandom_range(2));
      case ($urandom_range(19))
        0: r.req_size = '0;
        1: r.req_size = thr_now;
        2: r.req_size = thr_now - 40'd1;
        3: r.req_size = 40'({$urandom, $urandom});
        default: r.req_size = 40'($urandom_range(1, 32'(size_cap)));
      endcase
      if ($urandom_range(99) < 80) r.align_log2 = 6'($urandom_range(6));
    end
  endtask

  task automatic run_setting(input logic [39:0] bs, input logic [39:0] thr,
                             input logic [5:0] tc, input logic [39:0] cap,
                             input int items, input int first, input int total);
    req_t r;
    drain();
    write_reg(CFG_BLOCK_SIZE, bs);
    write_reg(CFG_DED_THRESH, thr);
    write_reg(CFG_TYPE_COUNT, 40'(tc));
    cfg_we   <= 1'b0;
    thr_now  = thr;
    size_cap = cap;
    n_settings++;
    for (int k = 0; k < items; k++) begin
      case (((first + k) * 3) / total)
        0: begin send_idle = 24; recv_idle = 87; end
        1: begin send_idle = 87; recv_idle = 24; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      random_request(r);
      send_request(r);
    end
  endtask

  initial begin
    req_t dir_q[$];
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_BLOCK_SIZE;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.req   = '0;
    send_idle    = 24;
    recv_idle    = 87;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_q.insert(dir_q.size(), alloc_req(40'd4096, 6'd12, 5'd0, 1'b0));
    dir_q.insert(dir_q.size(), alloc_req(40'd100, 6'd0, 5'd0, 1'b0));
    dir_q.insert(dir_q.size(), alloc_req(40'd64, 6'd8, 5'd0, 1'b0));
    dir_q.insert(dir_q.size(), alloc_req(40'hFF_FFFF_FFFF, 6'd0, 5'd3, 1'b1));
    dir_q.insert(dir_q.size(), alloc_req(40'd33554432, 6'd0, 5'd0, 1'b0));
    dir_q.insert(dir_q.size(), alloc_req(40'd0, 6'd0, 5'd5, 1'b1));
    dir_q.insert(dir_q.size(), alloc_req(40'd1, 6'd63, 5'd0, 1'b0));
    dir_q.insert(dir_q.size(), alloc_req(40'd1, 6'd39, 5'd0, 1'b0));
    dir_q.insert(dir_q.size(), alloc_req(40'd33554431, 6'd0, 5'd31, 1'b1));
    dir_q.insert(dir_q.size(), free_req(1'b0, 1'b0, 4'd0, 40'd4096, 40'd100));
    dir_q.insert(dir_q.size(), free_req(1'b1, 1'b0, 4'd15, 40'd0, 40'd8));
    dir_q.insert(dir_q.size(), free_req(1'b1, 1'b0, 4'd0, 40'd4096, 40'd100));
    dir_q.insert(dir_q.size(), free_req(1'b1, 1'b0, 4'd1, 40'd0, 40'd0));
    dir_q.insert(dir_q.size(), free_req(1'b1, 1'b1, 4'd0, 40'd0, 40'hFF_FFFF_FFFF));
    dir_q.insert(dir_q.size(), free_req(1'b1, 1'b1, 4'd0, 40'd0, 40'd0));
    dir_q.insert(dir_q.size(), free_req(1'b1, 1'b1, 4'd0, 40'd0, 40'd1));
    dir_q.insert(dir_q.size(), free_req(1'b1, 1'b0, 4'd0, 40'd4352, 40'd64));
    dir_q.insert(dir_q.size(), free_req(1'b1, 1'b0, 4'd0, 40'd0, 40'd4096));
    foreach (dir_q[i]) send_request(dir_q[i]);

    run_setting(40'd67108864, 40'd33554432, 6'd32, 40'd1048576, 130, 0, 690);
    run_setting(40'd4096, 40'd2048, 6'd4, 40'd256, 150, 130, 690);
    run_setting(40'd1, 40'hFF_FFFF_FFFF, 6'd32, 40'd64, 120, 280, 690);
    run_setting(40'hFF_FFFF_FFFF, 40'd1, 6'd0, 40'd64, 60, 400, 690);
    run_setting(40'd1024, 40'd512, 6'd32, 40'd48, 140, 460, 690);
    run_setting(40'h80_0000_0000, 40'h40_0000_0000, 6'd3, 40'd1073741824, 90, 600, 690);

    drain();
    repeat (200) @(posedge clk_i);
    $display("%0d requests (%0d allocate, %0d free) across %0d register settings",
             n_alloc + n_free, n_alloc, n_free, n_settings + 1);
    $display("%0d responses came back ok, the rest carried error or ignore codes",
             n_ok);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
